// ----- rtl/aac_pkg.sv -----
// Shared types, constants and elaboration-time functions for the arcsine allpass chain.
// Holds the arcsine point generator used to fill the per-cell ROMs. No dependencies.
package aac_pkg;

	localparam int DELAY_DEPTH           = 2048;
	localparam int ARCSINE_TABLE_ENTRIES = 1024;

	localparam int PTR_W     = $clog2(DELAY_DEPTH);
	localparam int IDX_W     = $clog2(ARCSINE_TABLE_ENTRIES + 1);
	localparam int LEN_W     = 11;
	localparam int SAMPLE_W  = 24;
	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 28;
	localparam int CFG_IDX_W = 2;
	localparam int SCALE_W   = 25;

	localparam int NUM_ASIN     = 5;
	localparam int NUM_ALLPASS  = 4;

	localparam int SAMPLE_MAX = 8388607;
	localparam int SAMPLE_MIN = -8388608;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_FIRST  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_SECOND = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_THIRD  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_FOURTH = CFG_IDX_W'(3);

	localparam logic [LEN_W-1:0] LENGTH_FIRST_RST  = LEN_W'(149);
	localparam logic [LEN_W-1:0] LENGTH_SECOND_RST = LEN_W'(179);
	localparam logic [LEN_W-1:0] LENGTH_THIRD_RST  = LEN_W'(191);
	localparam logic [LEN_W-1:0] LENGTH_FOURTH_RST = LEN_W'(223);

	typedef logic signed [DATA_W-1:0]   q28_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [PTR_W-1:0]           ptr_t;
	typedef logic [LEN_W-1:0]           len_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	localparam q28_t ONE_Q28     = q28_t'(32'sh1000_0000);
	localparam q28_t NEG_ONE_Q28 = q28_t'(-32'sh1000_0000);

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// 0.63679 in Q0.24
	localparam logic signed [SCALE_W-1:0] OUT_SCALE = SCALE_W'(10683573);

	// pipeline control broadcast to the delay cells
	typedef struct packed {
		logic en;       // whole chain advances
		logic clr;      // clearing pass running
		ptr_t clr_addr; // entry being cleared
	} pipe_ctl_t;

	// clamp a 33-bit signed sum to 32-bit signed
	function automatic q28_t sat32(input logic signed [DATA_W:0] v);
		if (v[DATA_W] != v[DATA_W-1]) begin
			return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end
		return v[DATA_W-1:0];
	endfunction

	// highest usable index of a delay line
	function automatic ptr_t clamp_len(input len_t len);
		if (int'(len) > DELAY_DEPTH - 1) begin
			return PTR_W'(DELAY_DEPTH - 1);
		end
		return PTR_W'(len);
	endfunction

	// downward step of a delay pointer, wrapping to the line length
	function automatic ptr_t wrap_dec(input ptr_t p, input ptr_t lim);
		if (p == '0 || (p - PTR_W'(1)) > lim) begin
			return lim;
		end
		return p - PTR_W'(1);
	endfunction

	// Taylor denominators (2n)(2n+1) held as reciprocals scaled by 2**RECIP_SH;
	// (t * m) >> RECIP_SH equals floor(t / d) for every t below 2**36
	localparam int          RECIP_SH  = 45;
	localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SH;
	localparam logic [10:1][63:0] TAYLOR_RECIP = {
		(RECIP_ONE + 64'd419) / 64'd420,
		(RECIP_ONE + 64'd341) / 64'd342,
		(RECIP_ONE + 64'd271) / 64'd272,
		(RECIP_ONE + 64'd209) / 64'd210,
		(RECIP_ONE + 64'd155) / 64'd156,
		(RECIP_ONE + 64'd109) / 64'd110,
		(RECIP_ONE + 64'd71) / 64'd72,
		(RECIP_ONE + 64'd41) / 64'd42,
		(RECIP_ONE + 64'd19) / 64'd20,
		(RECIP_ONE + 64'd5) / 64'd6
	};

	// truncating quotient of a Taylor term by its denominator
	function automatic longint unsigned taylor_quot(input longint unsigned t, input int n);
		logic [127:0] prod;
		prod = {64'd0, t} * {64'd0, TAYLOR_RECIP[n]};
		return prod[RECIP_SH +: 64];
	endfunction

	// sine in Q30, Taylor series through the x**21 term (eleven terms), truncating after each step
	function automatic longint unsigned sine_q30(input longint unsigned th);
		longint unsigned term;
		longint          sum;
		term = th;
		sum  = longint'(th);
		for (int n = 1; n <= 10; n++) begin
			term = (term * th) >> 30;
			term = (term * th) >> 30;
			term = taylor_quot(term, n);
			if ((n & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return (sum < 0) ? 64'd0 : longint'(sum);
	endfunction

	// table point k: bitwise search for asin(k/N), rounded to Q3.28
	function automatic q28_t asin_point(input int k);
		longint unsigned target;
		longint unsigned th;
		longint unsigned c;
		target = (longint'(k) << 30) / ARCSINE_TABLE_ENTRIES;
		th     = 64'd0;
		for (int b = 30; b >= 0; b--) begin
			c = th | (64'd1 << b);
			if (c <= HALF_PI_Q30 && sine_q30(c) <= target) begin
				th = c;
			end
		end
		return q28_t'((th + 64'd2) >> 2);
	endfunction

	localparam q28_t ASIN_MAX = asin_point(ARCSINE_TABLE_ENTRIES);

endpackage

// ----- rtl/aac_if.sv -----
// Channel interfaces of the arcsine allpass chain: sample in, sample out, config write.
// Depends on aac_pkg for payload types.
interface aac_in_if;
	logic                  valid;
	logic                  ready;
	aac_pkg::sample_t      sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface aac_out_if;
	logic                  valid;
	logic                  ready;
	aac_pkg::sample_t      sample_out;
	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

interface aac_cfg_if;
	logic                  valid;
	logic                  ready;
	aac_pkg::cfg_idx_t     index;
	aac_pkg::len_t         data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/aac_asin_cell.sv -----
// Clip-and-arcsine cell: three stages, constant ROM with two read ports, interpolation.
// Depends on aac_pkg (table generator, types).
module aac_asin_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  aac_pkg::q28_t x_in,
	output logic          v_out,
	output aac_pkg::q28_t y_out
);
	localparam int E      = aac_pkg::ARCSINE_TABLE_ENTRIES;
	localparam int FW     = aac_pkg::FRAC_W;
	localparam int IW     = aac_pkg::IDX_W;
	localparam int POS_W  = FW + IW;
	localparam int PROD_W = 2 * FW + 6;

	aac_pkg::q28_t rom [0:E];

	for (genvar k = 0; k <= E; k++) begin : g_rom
		localparam aac_pkg::q28_t POINT = aac_pkg::asin_point(k);
		assign rom[k] = POINT;
	end

	// stage 0: clip, magnitude, table position
	aac_pkg::q28_t    xc;
	aac_pkg::q28_t    mag_full;
	logic             neg;
	logic [FW:0]      mag;
	logic [POS_W-1:0] pos;
	logic [IW-1:0]    idx;
	logic [IW-1:0]    idx_hi;

	always_comb begin
		neg = x_in[aac_pkg::DATA_W-1];
		if (x_in > aac_pkg::ONE_Q28) begin
			xc = aac_pkg::ONE_Q28;
		end else if (x_in < aac_pkg::NEG_ONE_Q28) begin
			xc = aac_pkg::NEG_ONE_Q28;
		end else begin
			xc = x_in;
		end
		mag_full = neg ? -xc : xc;
		mag      = mag_full[FW:0];
		pos      = POS_W'(mag) * POS_W'(E);
		idx      = pos[POS_W-1:FW];
		// at the top point both reads hit the last entry, slope is zero
		idx_hi   = (idx == IW'(E)) ? idx : idx + IW'(1);
	end

	aac_pkg::q28_t            lo_s1, hi_s1, lo_s2, y_s3;
	logic [FW-1:0]            frac_s1;
	logic                     neg_s1, neg_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s1, v_s2, v_s3;

	logic signed [aac_pkg::DATA_W:0] diff;
	logic signed [PROD_W-1:0]        prod;
	logic signed [PROD_W-1:0]        step;
	aac_pkg::q28_t                   val;

	always_comb begin
		diff = {hi_s1[aac_pkg::DATA_W-1], hi_s1} - {lo_s1[aac_pkg::DATA_W-1], lo_s1};
		prod = PROD_W'(diff) * PROD_W'($signed({1'b0, frac_s1}));
		step = prod_s2 >>> FW;
		val  = lo_s2 + step[aac_pkg::DATA_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= rom[idx];
			hi_s1   <= rom[idx_hi];
			frac_s1 <= pos[FW-1:0];
			neg_s1  <= neg;
			prod_s2 <= prod;
			lo_s2   <= lo_s1;
			neg_s2  <= neg_s1;
			y_s3    <= neg_s2 ? -val : val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign v_out = v_s3;
	assign y_out = y_s3;

	// interpolation never leaves the table's range
	a_asin_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (y_s3 <= aac_pkg::ASIN_MAX && y_s3 >= -aac_pkg::ASIN_MAX))
		else $error("arcsine cell result outside table range");

endmodule

// ----- rtl/aac_allpass_cell.sv -----
// Single-delay allpass cell: one delay-line memory, down-counting pointer, three stages.
// Depends on aac_pkg (pointer helpers, saturation, control struct).
module aac_allpass_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  aac_pkg::pipe_ctl_t ctl,
	input  aac_pkg::len_t      len,
	input  logic               v_in,
	input  aac_pkg::q28_t      x_in,
	output logic               v_out,
	output aac_pkg::q28_t      y_out
);
	localparam int DW = aac_pkg::DATA_W;

	aac_pkg::q28_t line_mem [0:aac_pkg::DELAY_DEPTH-1];

	aac_pkg::ptr_t ptr_q;
	aac_pkg::ptr_t lim;
	aac_pkg::ptr_t tap_addr;

	assign lim      = aac_pkg::clamp_len(len);
	assign tap_addr = aac_pkg::wrap_dec(ptr_q, lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= aac_pkg::PTR_W'(1);
		end else if (ctl.en && v_in) begin
			ptr_q <= tap_addr;
		end
	end

	// stage 0: tap read issued; stage 1: y formed and written back
	aac_pkg::q28_t x_s1, rd_s1, fwd_d_s1, y_s2, add_s2, y_s3;
	aac_pkg::ptr_t p_s1;
	logic          self_s1, fwd_s1;
	logic          v_s1, v_s2, v_s3;

	aac_pkg::q28_t        tap, half_tap, y_new, half_y;
	logic                 we;
	aac_pkg::ptr_t        wa;
	aac_pkg::q28_t        wd;

	always_comb begin
		tap      = fwd_s1 ? fwd_d_s1 : rd_s1;
		half_tap = tap >>> 1;
		y_new    = aac_pkg::sat32({x_s1[DW-1], x_s1} - {half_tap[DW-1], half_tap});
		half_y   = y_s2 >>> 1;
		we       = ctl.clr || (ctl.en && v_s1);
		wa       = ctl.clr ? ctl.clr_addr : p_s1;
		wd       = ctl.clr ? '0 : y_new;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			line_mem[wa] <= wd;
		end
		if (ctl.en) begin
			rd_s1 <= line_mem[tap_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			x_s1     <= x_in;
			p_s1     <= ptr_q;
			// length zero: the entry just written is its own added tap
			self_s1  <= (tap_addr == ptr_q);
			// the item ahead writes this address in the same cycle
			fwd_s1   <= v_s1 && (p_s1 == tap_addr);
			fwd_d_s1 <= y_new;
			y_s2     <= y_new;
			add_s2   <= self_s1 ? y_new : tap;
			y_s3     <= aac_pkg::sat32({half_y[DW-1], half_y} + {add_s2[DW-1], add_s2});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ctl.en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign v_out = v_s3;
	assign y_out = y_s3;

	a_ptr_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ctl.en && v_in) |-> ptr_q <= $past(lim))
		else $error("allpass pointer beyond line length");

	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr |-> !(v_in || v_s1 || v_s2 || v_s3))
		else $error("item in allpass cell during clearing pass");

endmodule

// ----- rtl/arcsine_allpass_chain.sv -----
// Throughput: one transfer per cycle while no clearing pass runs; the nine-cell chain
// (5 arcsine, 4 allpass) plus the output multiply advance together and hold only while
// the output register waits. Reset: lengths return to 149/179/191/223, pointers to one;
// the four delay lines are then cleared one entry a cycle over all DELAY_DEPTH (2048)
// entries, with no input taken meanwhile.
// Configuration writes are taken at any time, including during the clearing pass.
module arcsine_allpass_chain (
	input logic        clk,
	input logic        arst_n,
	aac_cfg_if.sink    cfg,
	aac_in_if.sink     feed,
	aac_out_if.source  result
);
	localparam int NA     = aac_pkg::NUM_ASIN;
	localparam int NP     = aac_pkg::NUM_ALLPASS;
	localparam int DW     = aac_pkg::DATA_W;
	localparam int SW     = aac_pkg::SAMPLE_W;
	localparam int PROD_W = DW + aac_pkg::SCALE_W;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< 28;
	localparam logic signed [PROD_W-1:0] R_MAX      = PROD_W'(aac_pkg::SAMPLE_MAX);
	localparam logic signed [PROD_W-1:0] R_MIN      = PROD_W'(aac_pkg::SAMPLE_MIN);
	localparam aac_pkg::ptr_t CLR_LAST = aac_pkg::PTR_W'(aac_pkg::DELAY_DEPTH - 1);

	// ---- configuration: delay-line lengths ----
	aac_pkg::len_t len_q [NP];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q[0] <= aac_pkg::LENGTH_FIRST_RST;
			len_q[1] <= aac_pkg::LENGTH_SECOND_RST;
			len_q[2] <= aac_pkg::LENGTH_THIRD_RST;
			len_q[3] <= aac_pkg::LENGTH_FOURTH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				aac_pkg::REG_LENGTH_FIRST:  len_q[0] <= cfg.data;
				aac_pkg::REG_LENGTH_SECOND: len_q[1] <= cfg.data;
				aac_pkg::REG_LENGTH_THIRD:  len_q[2] <= cfg.data;
				aac_pkg::REG_LENGTH_FOURTH: len_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---- clearing pass over the delay lines after reset ----
	logic          clr_busy_q;
	aac_pkg::ptr_t clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + aac_pkg::PTR_W'(1);
			if (clr_addr_q == CLR_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ---- pipeline control ----
	// The whole chain moves when the output register is empty or being emptied.
	logic               out_valid_q;
	aac_pkg::sample_t   out_q;
	logic               en;
	logic               take;
	aac_pkg::pipe_ctl_t ctl;

	assign en          = !out_valid_q || result.ready;
	assign feed.ready  = en && !clr_busy_q;
	assign take        = feed.valid && feed.ready;
	assign ctl.en       = en;
	assign ctl.clr      = clr_busy_q;
	assign ctl.clr_addr = clr_addr_q;

	// Q1.23 widened to Q3.28
	aac_pkg::q28_t x0;
	assign x0 = {{(DW - SW - 5){feed.sample_in[SW-1]}}, feed.sample_in, 5'b0};

	// ---- chain of cells: arcsine, allpass, arcsine, ... , arcsine ----
	logic          va [NA];
	aac_pkg::q28_t da [NA];
	logic          vp [NP];
	aac_pkg::q28_t dp [NP];

	for (genvar i = 0; i < NA; i++) begin : g_asin
		if (i == 0) begin : g_head
			aac_asin_cell u_asin (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.v_in   (take),
				.x_in   (x0),
				.v_out  (va[i]),
				.y_out  (da[i])
			);
		end else begin : g_body
			aac_asin_cell u_asin (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.v_in   (vp[i-1]),
				.x_in   (dp[i-1]),
				.v_out  (va[i]),
				.y_out  (da[i])
			);
		end
	end

	for (genvar i = 0; i < NP; i++) begin : g_allpass
		aac_allpass_cell u_allpass (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.len    (len_q[i]),
			.v_in   (va[i]),
			.x_in   (da[i]),
			.v_out  (vp[i]),
			.y_out  (dp[i])
		);
	end

	// ---- output scale by 0.63679, round, saturate to Q1.23 ----
	logic signed [PROD_W-1:0] prod_s1;
	logic                     v_s1;
	logic signed [PROD_W-1:0] rnd;
	logic signed [PROD_W-1:0] r;
	aac_pkg::sample_t         r_sat;

	always_comb begin
		rnd = prod_s1 + ROUND_HALF;
		r   = rnd >>> 29;
		if (r > R_MAX) begin
			r_sat = aac_pkg::sample_t'(aac_pkg::SAMPLE_MAX);
		end else if (r < R_MIN) begin
			r_sat = aac_pkg::sample_t'(aac_pkg::SAMPLE_MIN);
		end else begin
			r_sat = r[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(da[NA-1]) * PROD_W'(aac_pkg::OUT_SCALE);
		end
		if (en && v_s1) begin
			out_q <= r_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= va[NA-1];
			out_valid_q <= v_s1;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_q;

	a_clear_progress: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q && clr_addr_q != CLR_LAST
			|=> clr_busy_q && clr_addr_q == $past(clr_addr_q) + aac_pkg::PTR_W'(1))
		else $error("delay-line clearing pass stopped early");

	a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !feed.ready && !out_valid_q)
		else $error("input taken or output offered during clearing pass");

endmodule
